### hdl/rbp_pkg.sv
// Shared types and codes for the RV64IC branch predecoder.
// Depends on nothing; used by riscv_branch_predecoder.
`timescale 1ns / 1ps

package rbp_pkg;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_TRUNC = 2'd1;
  localparam logic [1:0] ST_CDIS  = 2'd2;

  // Instruction lengths in bytes
  localparam logic [2:0] LEN_NONE = 3'd0;
  localparam logic [2:0] LEN_HALF = 3'd2;
  localparam logic [2:0] LEN_WORD = 3'd4;

  // Mnemonic classes
  localparam logic [4:0] MN_CNOP     = 5'd0;
  localparam logic [4:0] MN_CJ       = 5'd1;
  localparam logic [4:0] MN_CJALR    = 5'd2;
  localparam logic [4:0] MN_CEBREAK  = 5'd3;
  localparam logic [4:0] MN_UNK_HALF = 5'd4;
  localparam logic [4:0] MN_RET      = 5'd5;
  localparam logic [4:0] MN_JAL      = 5'd6;
  localparam logic [4:0] MN_JALR     = 5'd7;
  localparam logic [4:0] MN_BEQ      = 5'd8;
  localparam logic [4:0] MN_BNE      = 5'd9;
  localparam logic [4:0] MN_BBAD     = 5'd10;
  localparam logic [4:0] MN_BLT      = 5'd11;
  localparam logic [4:0] MN_BGE      = 5'd12;
  localparam logic [4:0] MN_BLTU     = 5'd13;
  localparam logic [4:0] MN_BGEU     = 5'd14;
  localparam logic [4:0] MN_ADDI     = 5'd15;
  localparam logic [4:0] MN_OPIMM    = 5'd16;
  localparam logic [4:0] MN_ADD      = 5'd17;
  localparam logic [4:0] MN_SUB      = 5'd18;
  localparam logic [4:0] MN_OP       = 5'd19;
  localparam logic [4:0] MN_LD       = 5'd20;
  localparam logic [4:0] MN_LW       = 5'd21;
  localparam logic [4:0] MN_SD       = 5'd22;
  localparam logic [4:0] MN_SW       = 5'd23;
  localparam logic [4:0] MN_UNK_WORD = 5'd24;

  // Major opcodes and fixed encodings
  localparam logic [31:0] ENC_RET    = 32'h0000_8067;
  localparam logic [6:0]  OPC_JAL    = 7'h6f;
  localparam logic [6:0]  OPC_JALR   = 7'h67;
  localparam logic [6:0]  OPC_BRANCH = 7'h63;
  localparam logic [6:0]  OPC_OPIMM  = 7'h13;
  localparam logic [6:0]  OPC_OP     = 7'h33;
  localparam logic [6:0]  OPC_LOAD   = 7'h03;
  localparam logic [6:0]  OPC_STORE  = 7'h23;
  localparam logic [6:0]  F7_SUB     = 7'h20;

  // Register index of the configuration port
  localparam logic REG_CEN = 1'b0;

  // Decoded word carried down the pipe
  typedef struct packed {
    logic [1:0]         status;
    logic [2:0]         length;
    logic [4:0]         mnem;
    logic               is_branch;
    logic               is_call;
    logic               is_terminal;
    logic               target_valid;
    logic [4:0]         dest_reg;
    logic [4:0]         src1_reg;
    logic [4:0]         src2_reg;
    logic signed [11:0] imm;
    logic signed [20:0] disp;
  } dec_t;

endpackage

### hdl/riscv_branch_predecoder.sv
// Top level of the RV64IC branch predecoder: decode, split target add, APB register.
// Depends on rbp_pkg.
`timescale 1ns / 1ps

// Usage
//   Input channel: drive in_* with start high; a word is taken at every
//   rising edge with start high and busy low. busy is always low, so a new
//   word may be offered every cycle.
//   Result channel: out_valid is high for exactly one cycle with the result
//   word on out_*; the receiver takes it at the edge that ends that cycle
//   and cannot stall the block.
//   Pipeline: an accepted word passes three register stages (decode, low half
//   of target add, high half of target add) before it is taken.
//   Throughput: one word per cycle, set by the fully pipelined datapath.
//   Config: APB register 0 (byte address 0), bit 0 = compressed_enable,
//   reset 1. pready is always high; write only while the pipe is empty.
//   Reset (rst_n low, synchronous) empties the pipe and restores
//   compressed_enable; no result is produced for words in flight.
//   ADDRESS_WIDTH (32..64) sets the width of the target adder; the target
//   wraps at that width and the upper port bits read zero.
module riscv_branch_predecoder #(
  parameter int ADDRESS_WIDTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               start,
  output logic               busy,
  input  logic [31:0]        in_instruction_word,
  input  logic [2:0]         in_bytes_available,
  input  logic [63:0]        in_fetch_address,
  // result channel
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic [2:0]         out_length,
  output logic [4:0]         out_mnemonic_code,
  output logic               out_is_branch,
  output logic               out_is_call,
  output logic               out_is_terminal,
  output logic               out_target_valid,
  output logic [63:0]        out_branch_target,
  output logic [4:0]         out_dest_reg,
  output logic [4:0]         out_src1_reg,
  output logic [4:0]         out_src2_reg,
  output logic signed [11:0] out_immediate,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int LO_W = ADDRESS_WIDTH / 2;
  localparam int HI_W = ADDRESS_WIDTH - LO_W;

  // ---------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------
  logic cen_r, cen_nxt;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    cen_nxt = cen_r;
    if (cfg_wr && (paddr[2] == rbp_pkg::REG_CEN)) begin
      cen_nxt = pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cen_r <= 1'b1;
    end else begin
      cen_r <= cen_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == rbp_pkg::REG_CEN) begin
      prdata[0] = cen_r;
    end
  end

  // never stalls: every stage moves every cycle
  assign busy = 1'b0;

  // ---------------------------------------------------------------------
  // Stage 1: decode
  // ---------------------------------------------------------------------
  rbp_pkg::dec_t dec_nxt;
  logic [15:0]   h;
  logic [31:0]   w;
  logic [11:0]   cj_off;
  logic [20:0]   jal_off;
  logic [12:0]   br_off;

  assign w = in_instruction_word;
  assign h = in_instruction_word[15:0];

  // CJ-format offset scramble
  assign cj_off = {h[12], h[8], h[10:9], h[6], h[7], h[2], h[11], h[5:3], 1'b0};
  assign jal_off = {w[31], w[19:12], w[20], w[30:21], 1'b0};
  assign br_off  = {w[31], w[7], w[30:25], w[11:8], 1'b0};

  always_comb begin
    dec_nxt = '0;
    if (in_bytes_available < 3'd2) begin
      dec_nxt.status = rbp_pkg::ST_TRUNC;
    end else if (w[1:0] != 2'b11) begin
      // 16-bit compressed
      if (!cen_r) begin
        dec_nxt.status = rbp_pkg::ST_CDIS;
      end else begin
        dec_nxt.length = rbp_pkg::LEN_HALF;
        if (h == 16'h0001) begin
          dec_nxt.mnem = rbp_pkg::MN_CNOP;
        end else if (h[1:0] == 2'b01 && h[15:13] == 3'd5) begin
          dec_nxt.mnem         = rbp_pkg::MN_CJ;
          dec_nxt.is_branch    = 1'b1;
          dec_nxt.is_terminal  = 1'b1;
          dec_nxt.target_valid = 1'b1;
          dec_nxt.disp         = {{9{cj_off[11]}}, cj_off};
        end else if (h[1:0] == 2'b10 && h[15:13] == 3'd4 && h[12] && h[6:2] == 5'd0) begin
          if (h[11:7] != 5'd0) begin
            dec_nxt.mnem      = rbp_pkg::MN_CJALR;
            dec_nxt.is_branch = 1'b1;
            dec_nxt.is_call   = 1'b1;
            dec_nxt.src1_reg  = h[11:7];
          end else begin
            dec_nxt.mnem        = rbp_pkg::MN_CEBREAK;
            dec_nxt.is_terminal = 1'b1;
          end
        end else begin
          dec_nxt.mnem = rbp_pkg::MN_UNK_HALF;
        end
      end
    end else if (in_bytes_available < 3'd4) begin
      dec_nxt.status = rbp_pkg::ST_TRUNC;
    end else begin
      // 32-bit
      dec_nxt.length   = rbp_pkg::LEN_WORD;
      dec_nxt.dest_reg = w[11:7];
      dec_nxt.src1_reg = w[19:15];
      dec_nxt.src2_reg = w[24:20];
      if (w[6:0] == rbp_pkg::OPC_JALR || w[6:0] == rbp_pkg::OPC_OPIMM) begin
        dec_nxt.imm = w[31:20];
      end
      if (w == rbp_pkg::ENC_RET) begin
        dec_nxt.mnem        = rbp_pkg::MN_RET;
        dec_nxt.is_terminal = 1'b1;
      end else begin
        unique case (w[6:0])
          rbp_pkg::OPC_JAL: begin
            dec_nxt.mnem         = rbp_pkg::MN_JAL;
            dec_nxt.is_branch    = 1'b1;
            dec_nxt.is_call      = (w[11:7] == 5'd1);
            dec_nxt.is_terminal  = (w[11:7] != 5'd1);
            dec_nxt.target_valid = 1'b1;
            dec_nxt.disp         = jal_off;
          end
          rbp_pkg::OPC_JALR: begin
            dec_nxt.mnem      = rbp_pkg::MN_JALR;
            dec_nxt.is_branch = 1'b1;
            dec_nxt.is_call   = (w[11:7] == 5'd1);
          end
          rbp_pkg::OPC_BRANCH: begin
            unique case (w[14:12])
              3'd0:    dec_nxt.mnem = rbp_pkg::MN_BEQ;
              3'd1:    dec_nxt.mnem = rbp_pkg::MN_BNE;
              3'd4:    dec_nxt.mnem = rbp_pkg::MN_BLT;
              3'd5:    dec_nxt.mnem = rbp_pkg::MN_BGE;
              3'd6:    dec_nxt.mnem = rbp_pkg::MN_BLTU;
              3'd7:    dec_nxt.mnem = rbp_pkg::MN_BGEU;
              default: dec_nxt.mnem = rbp_pkg::MN_BBAD;
            endcase
            dec_nxt.is_branch    = 1'b1;
            dec_nxt.target_valid = 1'b1;
            dec_nxt.disp         = {{8{br_off[12]}}, br_off};
          end
          rbp_pkg::OPC_OPIMM: begin
            dec_nxt.mnem = (w[14:12] == 3'd0) ? rbp_pkg::MN_ADDI : rbp_pkg::MN_OPIMM;
          end
          rbp_pkg::OPC_OP: begin
            if (w[14:12] == 3'd0) begin
              dec_nxt.mnem = (w[31:25] == rbp_pkg::F7_SUB) ? rbp_pkg::MN_SUB
                                                           : rbp_pkg::MN_ADD;
            end else begin
              dec_nxt.mnem = rbp_pkg::MN_OP;
            end
          end
          rbp_pkg::OPC_LOAD: begin
            dec_nxt.mnem = (w[14:12] == 3'd3) ? rbp_pkg::MN_LD : rbp_pkg::MN_LW;
          end
          rbp_pkg::OPC_STORE: begin
            dec_nxt.mnem = (w[14:12] == 3'd3) ? rbp_pkg::MN_SD : rbp_pkg::MN_SW;
          end
          default: begin
            dec_nxt.mnem = rbp_pkg::MN_UNK_WORD;
          end
        endcase
      end
    end
  end

  logic                     s1_v_r;
  rbp_pkg::dec_t            s1_dec_r;
  logic [ADDRESS_WIDTH-1:0] s1_pc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s1_dec_r <= dec_nxt;
    s1_pc_r  <= in_fetch_address[ADDRESS_WIDTH-1:0];
  end

  // ---------------------------------------------------------------------
  // Stage 2: low half of target add
  // ---------------------------------------------------------------------
  logic [ADDRESS_WIDTH-1:0] s1_disp_ext;
  logic [LO_W:0]            lo_sum;

  assign s1_disp_ext = {{(ADDRESS_WIDTH-21){s1_dec_r.disp[20]}}, s1_dec_r.disp};
  assign lo_sum = {1'b0, s1_pc_r[LO_W-1:0]} + {1'b0, s1_disp_ext[LO_W-1:0]};

  logic            s2_v_r;
  rbp_pkg::dec_t   s2_dec_r;
  logic [LO_W-1:0] s2_lo_r;
  logic            s2_carry_r;
  logic [HI_W-1:0] s2_pc_hi_r;
  logic [HI_W-1:0] s2_disp_hi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_dec_r     <= s1_dec_r;
    s2_lo_r      <= lo_sum[LO_W-1:0];
    s2_carry_r   <= lo_sum[LO_W];
    s2_pc_hi_r   <= s1_pc_r[ADDRESS_WIDTH-1:LO_W];
    s2_disp_hi_r <= s1_disp_ext[ADDRESS_WIDTH-1:LO_W];
  end

  // ---------------------------------------------------------------------
  // Stage 3: high half of target add, output register
  // ---------------------------------------------------------------------
  logic [HI_W-1:0]          hi_sum;
  logic [ADDRESS_WIDTH-1:0] tgt_nxt;

  assign hi_sum = s2_pc_hi_r + s2_disp_hi_r + {{(HI_W-1){1'b0}}, s2_carry_r};

  // target reads zero when there is none
  assign tgt_nxt = s2_dec_r.target_valid ? {hi_sum, s2_lo_r} : '0;

  logic                     out_v_r;
  rbp_pkg::dec_t            out_dec_r;
  logic [ADDRESS_WIDTH-1:0] out_tgt_r;
  logic [63:0]              tgt_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    out_dec_r <= s2_dec_r;
    out_tgt_r <= tgt_nxt;
  end

  always_comb begin
    tgt_ext = '0;
    tgt_ext[ADDRESS_WIDTH-1:0] = out_tgt_r;
  end

  assign out_valid         = out_v_r;
  assign out_status        = out_dec_r.status;
  assign out_length        = out_dec_r.length;
  assign out_mnemonic_code = out_dec_r.mnem;
  assign out_is_branch     = out_dec_r.is_branch;
  assign out_is_call       = out_dec_r.is_call;
  assign out_is_terminal   = out_dec_r.is_terminal;
  assign out_target_valid  = out_dec_r.target_valid;
  assign out_branch_target = tgt_ext;
  assign out_dest_reg      = out_dec_r.dest_reg;
  assign out_src1_reg      = out_dec_r.src1_reg;
  assign out_src2_reg      = out_dec_r.src2_reg;
  assign out_immediate     = out_dec_r.imm;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // every accepted word comes out at the end of the pipe
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##3 out_valid)
    else $error("result missing three cycles after accept");

  // error results carry no decode
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != rbp_pkg::ST_OK |->
      out_length == rbp_pkg::LEN_NONE && !out_is_branch && !out_target_valid)
    else $error("error result with decode fields");

  // no target means zero target
  a_tgt_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_target_valid |-> out_branch_target == 64'd0)
    else $error("branch target set without target_valid");

  // compressed results carry no rd/rs2
  a_half_regs: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_length == rbp_pkg::LEN_HALF |->
      out_dest_reg == 5'd0 && out_src2_reg == 5'd0)
    else $error("compressed result with register fields");

  // no result without an accepted word ahead of it in the pipe
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(s1_v_r, 2))
    else $error("result without accepted word");

endmodule
